@@ hw/rtl/zes_pkg.sv @@
// Shared types and constants for the zip entry header scanner.
`default_nettype none

package zes_pkg;

    // Fixed part of a local file header and its signature
    localparam int          FIXED_BYTES  = 30;
    localparam logic [31:0] LOCAL_SIG    = 32'h04034b50;
    localparam logic [15:0] ENCRYPT_MASK = 16'h0001;

    // Event queue between the parser and the output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // Output word width: fields packed from the name byte up, padded to bytes
    localparam int TDATA_W = 208;

    // Result kind, carried on tuser
    typedef enum logic [1:0] {
        KIND_NAME    = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    // Reason the scan stopped
    typedef enum logic [1:0] {
        REASON_BAD_SIG   = 2'd0,
        REASON_SHORT     = 2'd1,
        REASON_OVERRUN   = 2'd2,
        REASON_EXHAUSTED = 2'd3
    } reason_t;

    // One parser event: a main result, optionally followed by an end of scan
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  name_byte;
        logic [31:0] header_offset;
        logic [31:0] data_offset;
        logic [31:0] compressed_size;
        logic [31:0] uncompressed_size;
        logic [31:0] crc_value;
        logic [15:0] method;
        logic        encrypted;
        logic [15:0] name_length;
        reason_t     end_reason;
        logic        end_too;
        logic [31:0] end_offset;
        reason_t     end_reason2;
    } zes_event_t;

    // Output word for the main result of an event; unused fields are zero
    function automatic logic [TDATA_W-1:0] pack_main(input zes_event_t ev);
        logic [TDATA_W-1:0] w;
        begin
            w = '0;
            unique case (ev.kind)
                KIND_NAME:
                    w = {200'd0, ev.name_byte};
                KIND_SUMMARY:
                    w = {5'd0, 2'd0, ev.name_length, ev.encrypted, ev.method,
                         ev.crc_value, ev.uncompressed_size, ev.compressed_size,
                         ev.data_offset, ev.header_offset, 8'd0};
                KIND_END:
                    w = {5'd0, ev.end_reason, 161'd0, ev.header_offset, 8'd0};
                default:
                    w = '0;
            endcase
            return w;
        end
    endfunction

    // Output word for an end-of-scan result
    function automatic logic [TDATA_W-1:0] pack_end(input logic [31:0] offset,
                                                    input reason_t reason);
        return {5'd0, reason, 161'd0, offset, 8'd0};
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/zes_front.sv @@
// Parser front end: takes archive bytes, walks headers and emits events.
`default_nettype none

module zes_front #(
    parameter int OFFSET_BITS = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [7:0]          in_byte,
    input  wire                 cfg_we,
    input  wire  [31:0]         cfg_data,
    output logic                ev_push,
    output zes_pkg::zes_event_t ev,
    input  wire                 q_full
);
    import zes_pkg::*;

    localparam int LW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
    localparam int AW = LW + 2;

    // Byte offsets inside the fixed header
    localparam int OFS_FLAGS  = 6;
    localparam int OFS_METHOD = 8;
    localparam int OFS_CRC    = 14;
    localparam int OFS_CSIZE  = 18;
    localparam int OFS_USIZE  = 22;
    localparam int OFS_NLEN   = 26;
    localparam int OFS_ELEN   = 28;

    typedef enum logic [4:0] {
        PH_FIXED = 5'b00001,
        PH_NAME  = 5'b00010,
        PH_EXTRA = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_DONE  = 5'b10000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] len_reg, len_next;
    logic [31:0]            cnt_reg, cnt_next;
    logic [AW-1:0]          sum_reg, sum_next;
    logic [AW-1:0]          dofs_reg, dofs_next;
    logic [7:0]             hdr_reg [FIXED_BYTES];

    logic                   accept;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [31:0]            cnt_inc;
    logic [15:0]            nl, el;
    logic [31:0]            cs, us, crc;
    logic [15:0]            method, flags;
    logic [31:0]            sig;
    logic [2:0]             sc_start, sc_next;
    logic                   from_name, from_extra, from_data, from_done, entering;
    logic                   go_name, go_extra, go_data, ent_done;
    logic [AW-1:0]          need_end;

    // Start check: {fail, reason} for a header beginning at x
    function automatic logic [2:0] start_check(input logic [OFFSET_BITS-1:0] x,
                                               input logic [OFFSET_BITS-1:0] len);
        logic [OFFSET_BITS:0] top;
        begin
            top = {1'b0, x} + (OFFSET_BITS + 1)'(FIXED_BYTES);
            if (len <= x)
                return {1'b1, REASON_EXHAUSTED};
            else if (top > {1'b0, len})
                return {1'b1, REASON_SHORT};
            else
                return 3'd0;
        end
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready && (phase_reg != PH_DONE);
    assign pos_inc  = pos_reg + 1'b1;
    assign cnt_inc  = cnt_reg + 1'b1;

    // Header fields; the byte being taken may still be on the input
    assign sig    = {in_byte, hdr_reg[2], hdr_reg[1], hdr_reg[0]};
    assign nl     = {hdr_reg[OFS_NLEN+1], hdr_reg[OFS_NLEN]};
    assign el     = {(phase_reg == PH_FIXED) ? in_byte : hdr_reg[OFS_ELEN+1],
                     hdr_reg[OFS_ELEN]};
    assign cs     = {hdr_reg[OFS_CSIZE+3], hdr_reg[OFS_CSIZE+2],
                     hdr_reg[OFS_CSIZE+1], hdr_reg[OFS_CSIZE]};
    assign us     = {hdr_reg[OFS_USIZE+3], hdr_reg[OFS_USIZE+2],
                     hdr_reg[OFS_USIZE+1], hdr_reg[OFS_USIZE]};
    assign crc    = {hdr_reg[OFS_CRC+3], hdr_reg[OFS_CRC+2],
                     hdr_reg[OFS_CRC+1], hdr_reg[OFS_CRC]};
    assign method = {hdr_reg[OFS_METHOD+1], hdr_reg[OFS_METHOD]};
    assign flags  = {hdr_reg[OFS_FLAGS+1], hdr_reg[OFS_FLAGS]};

    assign sc_start = start_check(start_reg, len_reg);
    assign sc_next  = start_check(pos_inc, len_reg);
    assign need_end = sum_reg + AW'(el);

    // Clamp the written length to the offset range
    always_comb
    begin
        logic [LW-1:0] wd_ext;
        logic [LW-1:0] lim;
        wd_ext   = LW'(cfg_data);
        lim      = LW'({OFFSET_BITS{1'b1}});
        len_next = OFFSET_BITS'((wd_ext > lim) ? lim : wd_ext);
    end

    // Partial sums for the body fit and data offset, taken one byte early
    assign sum_next  = AW'(start_reg) + AW'(FIXED_BYTES) + AW'(nl) + AW'(cs);
    assign dofs_next = AW'(start_reg) + AW'(FIXED_BYTES) + AW'(nl);

    // Parse step
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        cnt_next   = cnt_reg;
        ev_push    = 1'b0;
        ev         = '0;
        from_name  = 1'b0;
        from_extra = 1'b0;
        from_data  = 1'b0;
        from_done  = 1'b0;

        if (accept)
        begin
            pos_next = pos_inc;
            unique case (phase_reg)
                PH_FIXED:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_reg == 32'd0 && sc_start[2])
                    begin
                        ev_push          = 1'b1;
                        ev.kind          = KIND_END;
                        ev.header_offset = 32'(start_reg);
                        ev.end_reason    = reason_t'(sc_start[1:0]);
                        phase_next       = PH_DONE;
                    end
                    else if (cnt_reg == 32'd3 && sig != LOCAL_SIG)
                    begin
                        ev_push          = 1'b1;
                        ev.kind          = KIND_END;
                        ev.header_offset = 32'(start_reg);
                        ev.end_reason    = REASON_BAD_SIG;
                        phase_next       = PH_DONE;
                    end
                    else if (cnt_reg == 32'(FIXED_BYTES - 1))
                    begin
                        ev_push          = 1'b1;
                        ev.header_offset = 32'(start_reg);
                        if (need_end > AW'(len_reg))
                        begin
                            ev.kind       = KIND_END;
                            ev.end_reason = REASON_OVERRUN;
                            phase_next    = PH_DONE;
                        end
                        else
                        begin
                            ev.kind              = KIND_SUMMARY;
                            ev.data_offset       = 32'(dofs_reg + AW'(el));
                            ev.compressed_size   = cs;
                            ev.uncompressed_size = us;
                            ev.crc_value         = crc;
                            ev.method            = method;
                            ev.encrypted         = |(flags & ENCRYPT_MASK);
                            ev.name_length       = nl;
                            from_name            = 1'b1;
                        end
                    end
                end
                PH_NAME:
                begin
                    ev_push      = 1'b1;
                    ev.kind      = KIND_NAME;
                    ev.name_byte = in_byte;
                    cnt_next     = cnt_inc;
                    from_extra   = (cnt_inc == 32'(nl));
                end
                PH_EXTRA:
                begin
                    cnt_next  = cnt_inc;
                    from_data = (cnt_inc == 32'(el));
                end
                PH_DATA:
                begin
                    cnt_next  = cnt_inc;
                    from_done = (cnt_inc == cs);
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        // Section entry, skipping empty sections
        entering = from_name || from_extra || from_data || from_done;
        go_name  = from_name && (nl != 16'd0);
        go_extra = !go_name && (from_name || from_extra) && (el != 16'd0);
        go_data  = !go_name && !go_extra && (from_name || from_extra || from_data)
                   && (cs != 32'd0);
        ent_done = entering && !go_name && !go_extra && !go_data;

        if (entering)
            cnt_next = 32'd0;
        if (go_name)
            phase_next = PH_NAME;
        else if (go_extra)
            phase_next = PH_EXTRA;
        else if (go_data)
            phase_next = PH_DATA;
        else if (ent_done)
        begin
            // Entry complete: next header starts here
            phase_next = PH_FIXED;
            start_next = pos_inc;
            if (sc_next[2])
            begin
                phase_next = PH_DONE;
                if (ev_push)
                begin
                    ev.end_too     = 1'b1;
                    ev.end_offset  = 32'(pos_inc);
                    ev.end_reason2 = reason_t'(sc_next[1:0]);
                end
                else
                begin
                    ev_push          = 1'b1;
                    ev.kind          = KIND_END;
                    ev.header_offset = 32'(pos_inc);
                    ev.end_reason    = reason_t'(sc_next[1:0]);
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIXED;
            pos_reg   <= '0;
            start_reg <= '0;
            cnt_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
                len_reg <= len_next;
        end
    end

    // Header bytes and partial sums
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_FIXED && cnt_reg < 32'(FIXED_BYTES))
            hdr_reg[cnt_reg[4:0]] <= in_byte;
        if (accept && phase_reg == PH_FIXED && cnt_reg == 32'(FIXED_BYTES - 2))
        begin
            sum_reg  <= sum_next;
            dofs_reg <= dofs_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/zes_fifo.sv @@
// Event queue between the parser and the output stage.
`default_nettype none

module zes_fifo (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  zes_pkg::zes_event_t push_ev,
    output logic                full,
    output logic                valid,
    output zes_pkg::zes_event_t head,
    input  wire                 pop
);
    import zes_pkg::*;

    zes_event_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_reg, wr_next;
    logic [QUEUE_PTR_W-1:0] rd_reg, rd_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;
    logic                   do_push, do_pop;

    assign full    = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointer and fill update
    always_comb
    begin
        wr_next    = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = do_pop ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_ev;
    end

endmodule

`default_nettype wire

@@ hw/rtl/zes_back.sv @@
// Output stage: turns queued events into result words, one per cycle while the receiver is ready.
`default_nettype none

module zes_back (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          q_valid,
    input  zes_pkg::zes_event_t          q_head,
    output logic                         q_pop,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [zes_pkg::TDATA_W-1:0]  out_data,
    output logic [1:0]                   out_user,
    output logic                         out_last
);
    import zes_pkg::*;

    logic               valid_reg, valid_next;
    logic               pend_reg, pend_next;
    logic [31:0]        pend_off_reg, pend_off_next;
    reason_t            pend_reason_reg, pend_reason_next;
    logic [TDATA_W-1:0] data_reg, data_next;
    kind_t              user_reg, user_next;
    logic               last_reg, last_next;
    logic               load;

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;
    assign out_last  = last_reg;

    // Output register is free when empty or being taken
    assign load  = !valid_reg || out_ready;
    assign q_pop = load && !pend_reg && q_valid;

    always_comb
    begin
        valid_next       = valid_reg;
        pend_next        = pend_reg;
        pend_off_next    = pend_off_reg;
        pend_reason_next = pend_reason_reg;
        data_next        = data_reg;
        user_next        = user_reg;
        last_next        = last_reg;
        if (load)
        begin
            if (pend_reg)
            begin
                // Trailing end of scan from the previous event
                valid_next = 1'b1;
                pend_next  = 1'b0;
                data_next  = pack_end(pend_off_reg, pend_reason_reg);
                user_next  = KIND_END;
                last_next  = 1'b1;
            end
            else if (q_valid)
            begin
                valid_next       = 1'b1;
                pend_next        = q_head.end_too;
                pend_off_next    = q_head.end_offset;
                pend_reason_next = q_head.end_reason2;
                data_next        = pack_main(q_head);
                user_next        = q_head.kind;
                last_next        = !q_head.end_too;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_off_reg    <= pend_off_next;
        pend_reason_reg <= pend_reason_next;
        data_reg        <= data_next;
        user_reg        <= user_next;
        last_reg        <= last_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/zip_entry_header_scanner.sv @@
// Zip entry header scanner: parser, event queue and output stage.
//
// Usage: feed the archive one byte per word on s_axis, from offset zero.
// Write archive_length through cfg_wr_en/cfg_wr_data before the scan starts.
// Results leave on m_axis: tuser gives the kind (name byte, entry summary,
// end of scan), tlast marks the final result caused by one input byte.
// Throughput: one byte per cycle while the event queue has room. A byte that
// causes two results (summary or last name byte followed by end of scan)
// takes two output words. A result passes through the event queue and then
// the output register before it is valid on m_axis.
// A four-word event queue sits between parser and output stage; when the
// receiver stalls, the queue fills and s_axis_tready drops, with no loss.
// After the end of scan, bytes are still taken and dropped.
// Reset: the scan restarts at offset zero, archive_length clears to zero and
// the queue and output register empty.
`default_nettype none

module zip_entry_header_scanner #(
    parameter int OFFSET_BITS = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,
    // data_byte [7:0]
    input  wire  [7:0]                   s_axis_tdata,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // name_byte [7:0], header_offset [39:8], data_offset [71:40],
    // compressed_size [103:72], uncompressed_size [135:104], crc_value [167:136],
    // method [183:168], encrypted [184], name_length [200:185],
    // end_reason [202:201], zero pad [207:203]
    output logic [zes_pkg::TDATA_W-1:0]  m_axis_tdata,
    // kind [1:0]
    output logic [1:0]                   m_axis_tuser,
    output logic                         m_axis_tlast,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    input  wire                          cfg_wr_en,
    input  wire  [31:0]                  cfg_wr_data
);
    import zes_pkg::*;

    zes_event_t fr_ev;
    zes_event_t q_head;
    logic       fr_push;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;

    zes_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .cfg_we   (cfg_wr_en),
        .cfg_data (cfg_wr_data),
        .ev_push  (fr_push),
        .ev       (fr_ev),
        .q_full   (q_full)
    );

    zes_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fr_push),
        .push_ev (fr_ev),
        .full    (q_full),
        .valid   (q_valid),
        .head    (q_head),
        .pop     (q_pop)
    );

    zes_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ hw/rtl/zes_checker.sv @@
// Port-level checks for the zip entry header scanner, bound to the top level.
`default_nettype none

module zes_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         m_axis_tvalid,
    input wire                         m_axis_tready,
    input wire [zes_pkg::TDATA_W-1:0]  m_axis_tdata,
    input wire [1:0]                   m_axis_tuser,
    input wire                         m_axis_tlast
);
    import zes_pkg::*;

    logic ended_reg;

    // Track an accepted end of scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ended_reg <= 1'b0;
        else if (m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_END)
            ended_reg <= 1'b1;
    end

    // Stalled word stays offered
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis_tvalid dropped while stalled");

    // Stalled word keeps its payload
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("m_axis payload changed while stalled");

    // End of scan is always the final result of its byte
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tlast)
        else $error("end of scan without tlast");

    // Name words carry nothing but the name byte
    a_name_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_NAME |-> m_axis_tdata[TDATA_W-1:8] == '0)
        else $error("name word carries stray fields");

    // Nothing follows an end of scan
    a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        ended_reg |-> !m_axis_tvalid)
        else $error("result after end of scan");

endmodule

bind zip_entry_header_scanner zes_checker u_zes_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
